@@ sv/lcdx_pkg.sv @@
// Shared types, constants and byte pattern helper for the LCD expander byte generator.
`default_nettype none

package lcdx_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int NUM_DIGITS  = 5;
   localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int DIGIT_IDX_WIDTH = $clog2(NUM_DIGITS);

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h27;
   localparam logic [7:0] CURSOR_BASE_ROW0     = 8'h80;
   localparam logic [7:0] CURSOR_BASE_ROW1     = 8'hC0;
   localparam logic [3:0] DATA_LOW_EN          = 4'hD;
   localparam logic [3:0] DATA_LOW_NO_EN       = 4'h9;
   localparam logic [3:0] CTRL_LOW_EN          = 4'h4;
   localparam logic [3:0] CTRL_LOW_LAST        = 4'h8;
   localparam logic [3:0] CTRL_LOW_NONE        = 4'h0;
   localparam logic [3:0] ASCII_DIGIT_HI       = 4'h3;

   typedef enum logic [1:0] {
      CMD_DATA    = 2'd0,
      CMD_CONTROL = 2'd1,
      CMD_CURSOR  = 2'd2,
      CMD_NUMBER  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  byte_value;
      logic [5:0]  column;
      logic        row;
      logic [15:0] number_value;
   } req_type;

   typedef struct packed {
      logic [7:0] bus_address;
      logic [7:0] expander_byte;
      logic       last_of_run;
   } rsp_type;

   // Byte number sub (0..3) of the four-byte run for one character or command.
   function automatic logic [7:0] expander_byte(input logic [7:0] ch, input logic is_ctrl,
                                                input logic [1:0] sub);
      logic [3:0] nib;
      logic [3:0] low;
      nib = sub[1] ? ch[3:0] : ch[7:4];
      if (!is_ctrl) begin
         low = sub[0] ? DATA_LOW_NO_EN : DATA_LOW_EN;
      end else begin
         case (sub)
            2'd1:    low = CTRL_LOW_NONE;
            2'd3:    low = CTRL_LOW_LAST;
            default: low = CTRL_LOW_EN;
         endcase
      end
      return {nib, low};
   endfunction

endpackage

`default_nettype wire

@@ sv/lcdx_bcd.sv @@
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
`default_nettype none

module lcdx_bcd
   import lcdx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] value,
   output logic                        done,
   output logic [BCD_WIDTH-1:0]        digits
);

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  count_ff, count_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      shift_in  = shift_ff;
      bcd_in    = bcd_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = '0;
         shift_in  = value;
         bcd_in    = '0;
      end else if (active_ff) begin
         bcd_in   = {adj[BCD_WIDTH-2:0], shift_ff[VALUE_WIDTH-1]};
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

`default_nettype wire

@@ sv/char_lcd_expander_byte_generator.sv @@
// Top level: request sequencer and output register of the LCD expander byte generator.
//
//  channel  dir  handshake             payload
//  req_     in   req_valid/req_stall   req_type (command, byte, column, row, number)
//  rsp_     out  rsp_valid/rsp_stall   rsp_type (bus address, expander byte, last)
//  csr_     in   csr_valid/csr_ready   7-bit device address
//
// Data, control and cursor requests: accepted in ST_IDLE, then 4 bytes, one a cycle while the output is not stalled.
// Number requests: accepted in ST_IDLE, then the 16-step BCD shift loop in ST_CONVERT,
// then 4 bytes per printed digit (up to 20).
// Output stalls hold the sequencer; req_stall is high whenever a request is in work.
// Reset is synchronous; the device address returns to 0x27.
`default_nettype none

module char_lcd_expander_byte_generator
   import lcdx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_payload,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_payload,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [6:0] csr_wdata
);

   state_type                  state_ff, state_in;
   logic [6:0]                 addr_ff;
   logic [7:0]                 char_ff, char_in;
   logic                       ctrl_ff, ctrl_in;
   logic [1:0]                 sub_ff, sub_in;
   logic [DIGIT_IDX_WIDTH-1:0] digit_ff, digit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       load;
   logic                       bcd_start;
   logic                       bcd_done;
   logic [BCD_WIDTH-1:0]       bcd_digits;
   logic [DIGIT_IDX_WIDTH-1:0] lead;
   logic [DIGIT_IDX_WIDTH-1:0] dsel;
   logic [7:0]                 cursor_byte;

   lcdx_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (req_payload.number_value),
      .done   (bcd_done),
      .digits (bcd_digits)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign cursor_byte = (req_payload.row ? CURSOR_BASE_ROW1 : CURSOR_BASE_ROW0)
                        + {2'b00, req_payload.column};
   assign dsel = digit_ff - 1'b1;

   always_comb begin
      lead = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (bcd_digits[4*i +: 4] != 4'd0) begin
            lead = DIGIT_IDX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      char_in      = char_ff;
      ctrl_in      = ctrl_ff;
      sub_in       = sub_ff;
      digit_in     = digit_ff;
      bcd_start    = 1'b0;
      load         = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            sub_in   = '0;
            digit_in = '0;
            if (req_valid) begin
               unique case (req_payload.command)
                  CMD_DATA: begin
                     char_in  = req_payload.byte_value;
                     ctrl_in  = 1'b0;
                     state_in = ST_EMIT;
                  end
                  CMD_CONTROL: begin
                     char_in  = req_payload.byte_value;
                     ctrl_in  = 1'b1;
                     state_in = ST_EMIT;
                  end
                  CMD_CURSOR: begin
                     char_in  = cursor_byte;
                     ctrl_in  = 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     ctrl_in   = 1'b0;
                     bcd_start = 1'b1;
                     state_in  = ST_CONVERT;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            if (bcd_done) begin
               digit_in = lead;
               char_in  = {ASCII_DIGIT_HI, bcd_digits[{lead, 2'b00} +: 4]};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load                 = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.bus_address   = {addr_ff, 1'b0};
               rsp_in.expander_byte = expander_byte(char_ff, ctrl_ff, sub_ff);
               rsp_in.last_of_run   = (sub_ff == 2'd3) && (digit_ff == '0);
               sub_in               = sub_ff + 1'b1;
               if (sub_ff == 2'd3) begin
                  if (digit_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     digit_in = dsel;
                     char_in  = {ASCII_DIGIT_HI, bcd_digits[{dsel, 2'b00} +: 4]};
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= DEVICE_ADDRESS_RESET;
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
         digit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
         digit_ff     <= digit_in;
         if (csr_valid && csr_ready) begin
            addr_ff <= csr_wdata;
         end
      end
      char_ff <= char_in;
      ctrl_ff <= ctrl_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> state_ff == ST_CONVERT)
      else $error("BCD done outside conversion");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_in.last_of_run) |=> state_ff == ST_IDLE)
      else $error("run did not end after last byte");

   a_digit_is_ascii: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && digit_ff != '0) |-> char_ff[7:4] == ASCII_DIGIT_HI)
      else $error("non-digit character in number run");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the LCD expander byte generator: random traffic, stalls, address writes.
module testbench;
   import lcdx_pkg::*;

   localparam logic [3:0] LOW_DATA_EN   = 4'hD;
   localparam logic [3:0] LOW_DATA_OFF  = 4'h9;
   localparam logic [3:0] LOW_CTRL_EN   = 4'h4;
   localparam logic [3:0] LOW_CTRL_OFF  = 4'h0;
   localparam logic [3:0] LOW_CTRL_LAST = 4'h8;
   localparam logic [7:0] ROW0_BASE     = 8'h80;
   localparam logic [7:0] ROW1_BASE     = 8'hC0;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [6:0] ADDR_AT_RESET = 7'h27;
   localparam int         TAIL_CYCLES   = 60;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_wdata   = '0;

   req_type    pending_requests[$];
   rsp_type    expected_bytes[$];
   rsp_type    oldest;
   logic [6:0] device_address = ADDR_AT_RESET;
   int         errors    = 0;
   int         idle_pct  = 34;
   int         stall_pct = 34;

   char_lcd_expander_byte_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Four expander bytes for one character or command byte.
   function automatic void queue_nibble_run(input logic [7:0] val, input logic is_ctrl,
                                            input logic tail);
      rsp_type    r;
      logic [3:0] pat[4];
      int         i;
      if (is_ctrl) begin
         pat = '{LOW_CTRL_EN, LOW_CTRL_OFF, LOW_CTRL_EN, LOW_CTRL_LAST};
      end else begin
         pat = '{LOW_DATA_EN, LOW_DATA_OFF, LOW_DATA_EN, LOW_DATA_OFF};
      end
      for (i = 0; i < 4; i++) begin
         r.bus_address   = {device_address, 1'b0};
         r.expander_byte = {(i < 2) ? val[7:4] : val[3:0], pat[i]};
         r.last_of_run   = tail && (i == 3);
         expected_bytes.push_back(r);
      end
   endfunction

   function automatic void queue_lcd_bytes(input req_type r);
      logic [7:0]  cursor_cmd;
      int unsigned v;
      int          digits[5];
      int          n;
      int          i;
      case (r.command)
         CMD_DATA: begin
            queue_nibble_run(r.byte_value, 1'b0, 1'b1);
         end
         CMD_CONTROL: begin
            queue_nibble_run(r.byte_value, 1'b1, 1'b1);
         end
         CMD_CURSOR: begin
            cursor_cmd = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, r.column};
            queue_nibble_run(cursor_cmd, 1'b1, 1'b1);
         end
         default: begin
            v = r.number_value;
            n = 0;
            if (v == 0) begin
               queue_nibble_run(ASCII_ZERO, 1'b0, 1'b1);
            end else begin
               while (v > 0) begin
                  digits[n] = v % 10;
                  n++;
                  v = v / 10;
               end
               for (i = n - 1; i >= 0; i--) begin
                  queue_nibble_run(8'(ASCII_ZERO + digits[i]), 1'b0, i == 0);
               end
            end
         end
      endcase
   endfunction

   function automatic req_type make_request(input cmd_type cmd, input logic [7:0] b,
                                            input logic [5:0] col, input logic row,
                                            input logic [15:0] num);
      req_type r;
      r.command      = cmd;
      r.byte_value   = b;
      r.column       = col;
      r.row          = row;
      r.number_value = num;
      return r;
   endfunction

   function automatic req_type random_request();
      logic [15:0] num;
      case ($urandom_range(0, 3))
         0:       num = 16'($urandom);
         1:       num = 16'($urandom_range(0, 9));
         2:       num = 16'($urandom_range(0, 999));
         default: num = 16'($urandom_range(10000, 65535));
      endcase
      return make_request(cmd_type'($urandom_range(0, 3)), 8'($urandom), 6'($urandom),
                          1'($urandom), num);
   endfunction

   task automatic add_random(input int count);
      repeat (count) pending_requests.push_back(random_request());
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_bytes.size() != 0);
   endtask

   task automatic write_address(input logic [6:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid      <= 1'b0;
      device_address  = v;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            queue_lcd_bytes(req_payload);
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_payload <= pending_requests.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte, expected none, actual addr %h byte %h last %b",
                        $time, rsp_payload.bus_address, rsp_payload.expander_byte,
                        rsp_payload.last_of_run);
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_payload !== oldest) begin
                  errors++;
                  $display("%0t: mismatch, expected addr %h byte %h last %b, actual addr %h byte %h last %b",
                           $time, oldest.bus_address, oldest.expander_byte, oldest.last_of_run,
                           rsp_payload.bus_address, rsp_payload.expander_byte,
                           rsp_payload.last_of_run);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // field extremes, every command, zero and five-digit numbers, cursor wrap columns
      pending_requests.push_back(make_request(CMD_DATA,    8'h00, 6'h3F, 1'b1, 16'hFFFF));
      pending_requests.push_back(make_request(CMD_DATA,    8'hFF, 6'h00, 1'b0, 16'h0000));
      pending_requests.push_back(make_request(CMD_DATA,    8'hA5, 6'h15, 1'b1, 16'h5A5A));
      pending_requests.push_back(make_request(CMD_DATA,    8'h5A, 6'h2A, 1'b0, 16'hA5A5));
      pending_requests.push_back(make_request(CMD_CONTROL, 8'h00, 6'h3F, 1'b1, 16'hFFFF));
      pending_requests.push_back(make_request(CMD_CONTROL, 8'hFF, 6'h00, 1'b0, 16'h0000));
      pending_requests.push_back(make_request(CMD_CONTROL, 8'h01, 6'h11, 1'b1, 16'h1234));
      pending_requests.push_back(make_request(CMD_CONTROL, 8'h28, 6'h22, 1'b0, 16'h4321));
      pending_requests.push_back(make_request(CMD_CURSOR,  8'hFF, 6'd0,  1'b0, 16'hFFFF));
      pending_requests.push_back(make_request(CMD_CURSOR,  8'h00, 6'd39, 1'b1, 16'h0000));
      pending_requests.push_back(make_request(CMD_CURSOR,  8'h00, 6'd63, 1'b1, 16'h0001));
      pending_requests.push_back(make_request(CMD_CURSOR,  8'h00, 6'd63, 1'b0, 16'h0002));
      pending_requests.push_back(make_request(CMD_CURSOR,  8'h00, 6'd40, 1'b1, 16'h0003));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'hFF, 6'h3F, 1'b1, 16'd0));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd9));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd10));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd100));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd10000));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd12345));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd65535));
      pending_requests.push_back(make_request(CMD_NUMBER,  8'h00, 6'h00, 1'b0, 16'd9999));
      wait_drained();

      write_address(7'h7F);
      add_random(120);
      wait_drained();

      // no idling on either side
      write_address(7'h00);
      idle_pct  = 0;
      stall_pct = 0;
      add_random(100);
      wait_drained();
      idle_pct  = 34;
      stall_pct = 34;

      write_address(7'($urandom_range(0, 127)));
      add_random(120);
      wait_drained();

      write_address(ADDR_AT_RESET);
      add_random(110);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/lcdx_pkg.sv
sv/lcdx_bcd.sv
sv/char_lcd_expander_byte_generator.sv
tb/testbench.sv
